FILE: rtl/core/ifb_pkg.sv
package ifb_pkg;

  localparam int SampleW = 16;
  localparam int PosInW  = 13;
  localparam int IdxW    = 11;
  // signed frame positions: holds -65536 .. 2*65536 for the largest period
  localparam int PosW    = 20;
  localparam int AbsW    = 16;
  localparam int GapW    = 18;
  localparam int DefaultPeriodFrames = 2048;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    logic              start;
    logic [AbsW-1:0]   dividend;
    logic [GapW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [AbsW-1:0]   quot;
    logic [GapW-1:0]   rem;
  } div_rsp_t;

endpackage

FILE: rtl/core/interpolating_frame_buffer.sv
// Channel | Direction | Carries
// in_     | slave     | tdata: sample, position, read_index; tuser: req_type
// out_    | master    | tdata: frame_sample (reads only)
//
// After reset a clearing pass writes zero to all 2*PERIOD_FRAMES frames, one a cycle,
// with in_tready low. A read passes through S_RD and S_RDOUT. A flush writes the last
// value to each frame after the last position up to the period end, then swaps banks.
// An update with a ramp runs the slope division, then writes each frame up to the new
// one. The frame memory has a single write port. A held result stalls the next read at
// its output stage, and in_tready stays low until that read moves on.
module interpolating_frame_buffer #(
  parameter int PERIOD_FRAMES = ifb_pkg::DefaultPeriodFrames
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample[15:0], position[28:16], read_index[39:29]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // frame_sample[15:0]
);
  import ifb_pkg::*;

  localparam int DEPTH = 2 * PERIOD_FRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [PosW-1:0] P_S   = PosW'(PERIOD_FRAMES);
  localparam logic signed [PosW-1:0] TWO_P = PosW'(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_RAMP, S_FLUSH, S_RD, S_RDOUT
  } state_t;

  state_t                     state_r;
  logic [AW:0]                clr_r;
  logic                       live_r;
  logic signed [PosW-1:0]     last_pos_r;
  logic signed [SampleW-1:0]  last_val_r;
  logic signed [PosW-1:0]     i_r;
  logic signed [PosW-1:0]     pos_r;
  logic signed [SampleW-1:0]  snew_r;
  logic                       neg_r;
  logic [GapW-1:0]            gap_r;
  logic [AbsW:0]              q_r;
  logic [GapW-1:0]            r_r;
  logic [IdxW-1:0]            idx_r;
  logic                       rd_zero_r;
  logic                       out_valid_r;
  logic [SampleW-1:0]         out_data_r;

  logic                       acc;
  req_t                       req;
  logic signed [SampleW-1:0]  in_sample;
  logic signed [PosW-1:0]     in_pos;
  logic [IdxW-1:0]            in_idx;
  logic signed [PosW-1:0]     gap;
  logic signed [SampleW:0]    diff;
  logic [AbsW-1:0]            absd;
  logic signed [PosW-1:0]     flush_start;
  logic signed [PosW-1:0]     lp_back;
  logic [GapW:0]              r_sum;
  logic signed [SampleW+1:0]  ramp_val;

  div_req_t                   dreq;
  div_rsp_t                   drsp;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [SampleW-1:0]         wdata;
  logic [AW-1:0]              raddr;
  logic [SampleW-1:0]         rdata;

  function automatic logic [AW-1:0] frame_addr(input logic signed [PosW-1:0] p,
                                                input logic live);
    logic signed [PosW-1:0] a;
    if (p < P_S) begin
      a = live ? p + P_S : p;
    end else begin
      a = live ? p - P_S : p;
    end
    return AW'(a);
  endfunction

  assign acc       = in_tvalid && in_tready;
  assign req       = req_t'(in_tuser);
  assign in_sample = in_tdata[15:0];
  assign in_pos    = PosW'(in_tdata[28:16]);
  assign in_idx    = in_tdata[39:29];
  assign in_tready = (state_r == S_IDLE);

  assign gap  = in_pos - last_pos_r;
  assign diff = (SampleW+1)'(in_sample) - (SampleW+1)'(last_val_r);
  assign absd = diff[SampleW] ? AbsW'(-diff) : AbsW'(diff);

  assign flush_start = (last_pos_r + 1 < 0) ? '0 : PosW'(last_pos_r + 1);
  assign lp_back     = (last_pos_r - P_S < -P_S) ? -P_S : last_pos_r - P_S;

  assign r_sum    = {1'b0, r_r} + {1'b0, drsp.rem};
  assign ramp_val = (SampleW+2)'(last_val_r)
                    + (neg_r ? -(SampleW+2)'(q_r) : (SampleW+2)'(q_r));

  assign dreq.start    = acc && req == REQ_UPDATE && gap > 1;
  assign dreq.dividend = absd;
  assign dreq.divisor  = GapW'(gap);

  ifb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = AW'(clr_r);
      end
      S_IDLE: begin
        // update without ramp writes its frame at once
        if (acc && req == REQ_UPDATE && gap <= 1 && in_pos < TWO_P) begin
          we    = 1'b1;
          waddr = frame_addr(in_pos, live_r);
          wdata = in_sample;
        end
      end
      S_RAMP: begin
        if (i_r < pos_r && i_r < TWO_P) begin
          we    = (i_r >= 0);
          waddr = frame_addr(i_r, live_r);
          wdata = SampleW'(ramp_val);
        end else begin
          we    = (pos_r < TWO_P);
          waddr = frame_addr(pos_r, live_r);
          wdata = snew_r;
        end
      end
      S_FLUSH: begin
        if (i_r < P_S) begin
          we    = 1'b1;
          waddr = frame_addr(i_r, live_r);
          wdata = last_val_r;
        end
      end
      default: ;
    endcase
  end

  assign raddr = frame_addr(PosW'(idx_r), live_r);

  ifb_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      live_r      <= 1'b0;
      last_pos_r  <= '0;
      last_val_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the output stage refills itself when a read is waiting
      if (out_valid_r && out_tready && state_r != S_RDOUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            case (req)
              REQ_UPDATE: begin
                if (gap > 1) begin
                  state_r <= S_DIV;
                  pos_r   <= in_pos;
                  snew_r  <= in_sample;
                  neg_r   <= diff[SampleW];
                  gap_r   <= GapW'(gap);
                  i_r     <= PosW'(last_pos_r + 1);
                end else begin
                  last_pos_r <= in_pos;
                  last_val_r <= in_sample;
                end
              end
              REQ_READ: begin
                idx_r     <= in_idx;
                rd_zero_r <= (PosW'(in_idx) >= P_S);
                state_r   <= S_RD;
              end
              REQ_FLUSH: begin
                i_r     <= flush_start;
                state_r <= S_FLUSH;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            q_r     <= (AbsW+1)'(drsp.quot);
            r_r     <= drsp.rem;
            state_r <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (i_r < pos_r && i_r < TWO_P) begin
            i_r <= PosW'(i_r + 1);
            // step k*|diff|/gap by one frame
            if (r_sum >= {1'b0, gap_r}) begin
              q_r <= q_r + (AbsW+1)'(drsp.quot) + 1'b1;
              r_r <= GapW'(r_sum - {1'b0, gap_r});
            end else begin
              q_r <= q_r + (AbsW+1)'(drsp.quot);
              r_r <= GapW'(r_sum);
            end
          end else begin
            last_pos_r <= pos_r;
            last_val_r <= snew_r;
            state_r    <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (i_r < P_S) begin
            i_r <= PosW'(i_r + 1);
          end else begin
            live_r     <= ~live_r;
            last_pos_r <= lp_back;
            state_r    <= S_IDLE;
          end
        end
        S_RD: begin
          state_r <= S_RDOUT;
        end
        S_RDOUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rd_zero_r ? '0 : rdata;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/ifb_ram.sv
module ifb_ram #(
  parameter int DEPTH = 2 * ifb_pkg::DefaultPeriodFrames,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ifb_pkg::SampleW-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [ifb_pkg::SampleW-1:0] rdata
);
  import ifb_pkg::*;

  logic [SampleW-1:0] mem [DEPTH];
  logic [SampleW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ifb_div.sv
module ifb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ifb_pkg::div_req_t   req,
  output ifb_pkg::div_rsp_t   rsp
);
  import ifb_pkg::*;

  localparam int CntW = $clog2(AbsW + 1);

  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [AbsW-1:0] quo_r;
  logic [GapW-1:0] rem_r;
  logic [GapW-1:0] dvs_r;
  logic [GapW:0]   trial;
  logic            fits;

  // one quotient bit a cycle, restoring
  assign trial = {rem_r, quo_r[AbsW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(AbsW);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? GapW'(trial - {1'b0, dvs_r}) : GapW'(trial);
        quo_r <= {quo_r[AbsW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ifb_pkg::*;

  localparam int P = 2048;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] sample;
    logic [12:0] position;
    logic [10:0] read_index;
  } frame_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  interpolating_frame_buffer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic signed [15:0] frames [0:2*P-1];
  logic               live_bank;
  int                 last_pos;
  int                 last_value;

  frame_req_t         pending_reqs [$];
  logic [15:0]        expected_samples [$];
  int                 mismatches;
  bit                 send_idle_ok;
  bit                 hold_receiver;
  bit                 pause_sender;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic void store_frame(int pos, int value);
    int offset;
    logic bank;
    if (pos < 0 || pos >= 2 * P) return;
    if (pos < P) begin
      bank = live_bank;
      offset = pos;
    end else begin
      bank = ~live_bank;
      offset = pos - P;
    end
    frames[bank * P + offset] = value[15:0];
  endfunction

  function automatic void predict(frame_req_t r);
    longint diff;
    longint step;
    int gap;
    int first;
    int newpos;
    int newval;
    case (req_t'(r.req))
      REQ_UPDATE: begin
        newval = $signed(r.sample);
        newpos = r.position;
        diff = longint'(newval) - longint'(last_value);
        gap = newpos - last_pos;
        first = (last_pos + 1 < 0) ? 0 : last_pos + 1;
        for (int i = first; i < newpos && i < 2 * P; i++) begin
          step = (longint'(i - last_pos) * diff) / longint'(gap);
          store_frame(i, last_value + int'(step));
        end
        store_frame(newpos, newval);
        last_pos = newpos;
        last_value = newval;
      end
      REQ_READ: begin
        expected_samples.push_back(r.read_index < P ? frames[live_bank * P + r.read_index] : 16'd0);
      end
      REQ_FLUSH: begin
        first = (last_pos + 1 < 0) ? 0 : last_pos + 1;
        for (int i = first; i < P; i++) store_frame(i, last_value);
        live_bank = ~live_bank;
        last_pos -= P;
        if (last_pos < -P) last_pos = -P;
      end
      default: ;
    endcase
  endfunction

  // input transactions, taken at the rising edge
  bit in_taken;
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      predict(pending_reqs.pop_front());
      in_taken = 1'b1;
    end
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    frame_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (send_gap > 0) send_gap--;
      else if (send_idle_ok && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
      // a transaction on offer stays put until taken
      if (!in_tvalid || in_taken) begin
        if (pending_reqs.size() > 0 && send_gap == 0 && !pause_sender) begin
          r = pending_reqs[0];
          in_tvalid <= 1'b1;
          in_tdata <= {r.read_index, r.position, r.sample};
          in_tuser <= r.req;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  int recv_gap = 0;
  always @(negedge clk) begin
    if (recv_gap > 0) recv_gap--;
    else if (send_idle_ok && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 16);
    out_tready <= !hold_receiver && recv_gap == 0;
  end

  // monitor
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame_sample %0d", $signed(out_tdata));
      end else begin
        want = expected_samples.pop_front();
        if (want !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("frame_sample mismatch: expected %0d got %0d",
                     $signed(want), $signed(out_tdata));
        end
      end
    end
  end

  function automatic frame_req_t mk(req_t k, int s, int p, int idx);
    frame_req_t r;
    r.req = k;
    r.sample = s[15:0];
    r.position = p[12:0];
    r.read_index = idx[10:0];
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
  endtask

  initial begin
    #1000000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int pos;
    for (int i = 0; i < 2 * P; i++) frames[i] = '0;
    live_bank = 0;
    last_pos = 0;
    last_value = 0;
    mismatches = 0;
    send_idle_ok = 1;
    hold_receiver = 0;
    pause_sender = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, backward positions, beyond window, unknown request
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_UPDATE, 32767, 10, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 5));
    pending_reqs.push_back(mk(REQ_UPDATE, -32768, 30, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 20));
    pending_reqs.push_back(mk(REQ_UPDATE, 100, 5, 0));
    pending_reqs.push_back(mk(REQ_UPDATE, -7, 6, 0));
    pending_reqs.push_back(mk(REQ_UPDATE, 1234, 2100, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 2047));
    pending_reqs.push_back(mk(REQ_FLUSH, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 40));
    pending_reqs.push_back(mk(REQ_NONE, -1, 8191, 2047));
    pending_reqs.push_back(mk(REQ_UPDATE, -32768, 8191, 0));
    pending_reqs.push_back(mk(REQ_FLUSH, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_FLUSH, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_FLUSH, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_UPDATE, 32767, 4095, 0));
    pending_reqs.push_back(mk(REQ_FLUSH, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 2047));
    pending_reqs.push_back(mk(REQ_READ, 0, 0, 1));
    wait_drained();

    // long receiver hold: reads pile up and stall the input
    hold_receiver = 1;
    for (int i = 0; i < 20; i++) pending_reqs.push_back(mk(REQ_READ, 0, 0, $urandom_range(0, 2047)));
    repeat (300) @(posedge clk);
    hold_receiver = 0;
    wait_drained();

    // random: mostly forward-moving updates up to position 8191, reads, occasional flush and no-op
    pos = 0;
    for (int n = 0; n < 260; n++) begin
      int k;
      k = $urandom_range(0, 19);
      if (n == 220) send_idle_ok = 0;
      if (k < 8) begin
        pos = (k == 0) ? $urandom_range(0, 8191) : pos + $urandom_range(1, 60);
        if (pos > 8191) pos = $urandom_range(0, 400);
        pending_reqs.push_back(mk(REQ_UPDATE, $urandom, pos, $urandom));
      end else if (k < 17) begin
        pending_reqs.push_back(mk(REQ_READ, $urandom, $urandom, $urandom_range(0, 2047)));
      end else if (k < 19) begin
        pending_reqs.push_back(mk(REQ_FLUSH, $urandom, $urandom, $urandom));
        pos = (pos > P) ? pos - P : 0;
      end else begin
        pending_reqs.push_back(mk(REQ_NONE, $urandom, $urandom, $urandom));
      end
      if (n == 130) begin
        wait_drained();
        pause_sender = 1;
        repeat (40) @(posedge clk);
        pause_sender = 0;
      end
    end
    wait_drained();
    repeat (5000) @(posedge clk);

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
